// ===== sv/srsw_pkg.sv =====
// Shared types and constants for the selective-repeat sender window.
// Used by selective_repeat_sender_window; no dependencies.
`timescale 1ns / 1ps

package srsw_pkg;

  localparam int CMD_W    = 2;
  localparam int ACTION_W = 2;
  localparam int WSEQ_W   = 5;
  localparam int PIDX_W   = 16;
  localparam int WIN_W    = 4;
  localparam int TIMER_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Item kinds on the input tuser.
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

  // Result kinds on the output tuser.
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEND   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESEND = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_DONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST   = 4'd10;
  localparam logic [TIMER_W-1:0] TIMEOUT_LIMIT_RST = 8'd20;
  localparam logic [PIDX_W-1:0]  TOTAL_PACKETS_RST = 16'd23;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 8'hFF;

  typedef struct packed {
    logic [PIDX_W-1:0]   pidx;
    logic [WSEQ_W-1:0]   wseq;
    logic [ACTION_W-1:0] action;
  } result_t;

endpackage

// ===== sv/srsw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module srsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/selective_repeat_sender_window.sv =====
// Selective-repeat sender window: top level with sequencer and slot state.
// Depends on srsw_pkg and srsw_ram (per-slot timer storage).
`timescale 1ns / 1ps

// One input beat gives one result beat. The block takes one item at a time.
// A start, a send or an ignored ack goes straight to the finish state. An
// accepted ack then slides the base one slot per cycle, by at most
// min(window_size, SEQ_COUNT) slots. A tick reads the timer RAM and writes it
// back one slot per cycle from the base over min(window_size, SEQ_COUNT)
// slots, filling the read pipeline first and draining it at the end; with a
// zero window it reads nothing. A result waits in the output register while
// the next item is taken; if that register still holds a result that has not
// been taken, the sequencer waits in its finish state and the input stays
// closed. Timer entries carry a valid bit each, so there is no clearing pass
// after reset. Configuration writes are taken at any time and must only be
// made while the block is idle.
module selective_repeat_sender_window #(
  parameter int SEQ_COUNT = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: ack_seq[4:0], zero padding [7:5]
  input  logic [7:0]  in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: wire_seq[4:0], packet_index[20:5], window_base[25:21], zero [31:26]
  output logic [31:0] out_tdata,
  // out_tuser: action[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = $clog2(SEQ_COUNT);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SEQ_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SLIDE = 2'd1;
  localparam logic [1:0] ST_TICK  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SW'(1);
  endfunction

  // Distance from one slot forward to another, modulo SEQ_COUNT.
  function automatic logic [SW-1:0] slot_dist(input logic [SW-1:0] from,
                                             input logic [SW-1:0] to);
    logic [SW:0] wrapped;
    wrapped = {1'b0, to} + (SW+1)'(SEQ_COUNT) - {1'b0, from};
    return (to >= from) ? to - from : wrapped[SW-1:0];
  endfunction

  logic [1:0] state_r, state_nxt;
  logic [SW-1:0] base_r, base_nxt;
  logic [SW-1:0] next_r, next_nxt;
  logic [srsw_pkg::PIDX_W-1:0] issued_r, issued_nxt;
  logic [SEQ_COUNT-1:0] free_r, free_nxt;
  logic [SEQ_COUNT-1:0] tv_r, tv_nxt;
  logic [srsw_pkg::WIN_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt;
  logic [SW-1:0] pj_r, pj_nxt;
  logic pv_r, pv_nxt;
  logic [SW-1:0] fj_r, fj_nxt;
  srsw_pkg::result_t res_r, res_nxt;

  logic [srsw_pkg::WIN_W-1:0]   ws_r;
  logic [srsw_pkg::TIMER_W-1:0] tl_r;
  logic [srsw_pkg::PIDX_W-1:0]  tp_r;

  logic out_valid_r;
  srsw_pkg::result_t out_res_r, out_res_nxt;
  logic [srsw_pkg::WSEQ_W-1:0] out_base_r;
  logic out_load;

  logic ram_we, ram_re;
  logic [srsw_pkg::TIMER_W-1:0] ram_wdata, ram_rdata;

  logic [srsw_pkg::CMD_W-1:0] cmd;
  logic [srsw_pkg::WSEQ_W-1:0] ack_seq, ack_m1;
  logic [SW-1:0] ack_slot;
  logic ack_ok, send_ok;
  logic [srsw_pkg::WIN_W-1:0] span;
  logic [srsw_pkg::TIMER_W-1:0] t_cur, aged;
  logic expired;
  logic in_acc;

  assign cmd      = in_tuser;
  assign ack_seq  = in_tdata[srsw_pkg::WSEQ_W-1:0];
  assign ack_m1   = ack_seq - srsw_pkg::WSEQ_W'(1);
  assign ack_slot = SW'(ack_m1);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign span = (32'(ws_r) < 32'(SEQ_COUNT)) ? ws_r : srsw_pkg::WIN_W'(SEQ_COUNT);

  assign ack_ok = (ack_seq != '0) && (32'(ack_seq) <= 32'(SEQ_COUNT)) &&
                  (32'(slot_dist(base_r, ack_slot)) < 32'(ws_r));
  assign send_ok = (32'(slot_dist(base_r, next_r)) < 32'(ws_r)) && free_r[next_r];

  // The pending slot's timer, aged once if the slot is still unacked and the timer is not saturated.
  assign t_cur   = tv_r[pj_r] ? ram_rdata : '0;
  assign aged    = (!free_r[pj_r] && t_cur != srsw_pkg::TIMER_MAX) ?
                   t_cur + srsw_pkg::TIMER_W'(1) : t_cur;
  assign expired = aged > tl_r;

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    next_nxt   = next_r;
    issued_nxt = issued_r;
    free_nxt   = free_r;
    tv_nxt     = tv_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    pj_nxt     = pj_r;
    pv_nxt     = pv_r;
    fj_nxt     = fj_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_wdata  = aged;
    ram_re     = 1'b0;
    out_res_nxt = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt   = '0;
          state_nxt = ST_FIN;
          unique case (cmd)
            srsw_pkg::CMD_START: begin
              base_nxt   = '0;
              next_nxt   = '0;
              issued_nxt = '0;
            end
            srsw_pkg::CMD_SEND: begin
              if (issued_r >= tp_r) begin
                res_nxt.action = srsw_pkg::ACT_DONE;
              end else if (send_ok) begin
                free_nxt[next_r] = 1'b0;
                res_nxt.action   = srsw_pkg::ACT_SEND;
                res_nxt.wseq     = srsw_pkg::WSEQ_W'({1'b0, next_r} + (SW+1)'(1));
                res_nxt.pidx     = issued_r;
                next_nxt         = slot_inc(next_r);
                issued_nxt       = issued_r + srsw_pkg::PIDX_W'(1);
              end
            end
            srsw_pkg::CMD_ACK: begin
              if (ack_ok) begin
                // Dropping the valid bit makes the timer read back as zero.
                free_nxt[ack_slot] = 1'b1;
                tv_nxt[ack_slot]   = 1'b0;
                cnt_nxt            = '0;
                state_nxt          = ST_SLIDE;
              end
            end
            srsw_pkg::CMD_TICK: begin
              cnt_nxt   = '0;
              ptr_nxt   = base_r;
              pv_nxt    = 1'b0;
              state_nxt = ST_TICK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SLIDE: begin
        if (cnt_r == span || base_r == next_r || !free_r[base_r]) begin
          state_nxt = ST_FIN;
        end else begin
          base_nxt = slot_inc(base_r);
          cnt_nxt  = cnt_r + srsw_pkg::WIN_W'(1);
        end
      end
      ST_TICK: begin
        // Read one slot ahead while the previous slot is aged and written back.
        if (pv_r) begin
          ram_we       = 1'b1;
          tv_nxt[pj_r] = 1'b1;
          if (res_r.action != srsw_pkg::ACT_RESEND && expired) begin
            free_nxt[pj_r] = 1'b0;
            ram_wdata      = '0;
            res_nxt.action = srsw_pkg::ACT_RESEND;
            res_nxt.wseq   = srsw_pkg::WSEQ_W'({1'b0, pj_r} + (SW+1)'(1));
            fj_nxt         = pj_r;
          end
        end
        if (cnt_r < span) begin
          ram_re  = 1'b1;
          pj_nxt  = ptr_r;
          pv_nxt  = 1'b1;
          ptr_nxt = slot_inc(ptr_r);
          cnt_nxt = cnt_r + srsw_pkg::WIN_W'(1);
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (res_r.action == srsw_pkg::ACT_RESEND) begin
          out_res_nxt.pidx = issued_r - srsw_pkg::PIDX_W'(slot_dist(fj_r, next_r));
        end
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      issued_r    <= '0;
      free_r      <= '1;
      tv_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      next_r   <= next_nxt;
      issued_r <= issued_nxt;
      free_r   <= free_nxt;
      tv_r     <= tv_nxt;
      pv_r     <= pv_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ptr_r <= ptr_nxt;
    pj_r  <= pj_nxt;
    fj_r  <= fj_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_res_r  <= out_res_nxt;
      out_base_r <= srsw_pkg::WSEQ_W'(base_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= srsw_pkg::WINDOW_SIZE_RST;
      tl_r <= srsw_pkg::TIMEOUT_LIMIT_RST;
      tp_r <= srsw_pkg::TOTAL_PACKETS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srsw_pkg::REG_WINDOW_SIZE:   ws_r <= cfg_data[srsw_pkg::WIN_W-1:0];
        srsw_pkg::REG_TIMEOUT_LIMIT: tl_r <= cfg_data[srsw_pkg::TIMER_W-1:0];
        srsw_pkg::REG_TOTAL_PACKETS: tp_r <= cfg_data[srsw_pkg::PIDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srsw_ram #(
    .WIDTH (srsw_pkg::TIMER_W),
    .DEPTH (SEQ_COUNT)
  ) u_timer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pj_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {6'd0, out_base_r, out_res_r.pidx, out_res_r.wseq};

`ifndef NO_ASSERTIONS
  // The next slot never runs further ahead of the base than the widest window.
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(slot_dist(base_r, next_r)) <= 15)
    else $error("next slot ran beyond the window");

  // The slide stops at the next slot.
  a_slide_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLIDE && base_r == next_r) |=> base_r == $past(base_r))
    else $error("window base slid past the next slot");

  // An accepted item keeps the input side closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken again before the item finished");

  // Finishing an item always presents its result and frees the sequencer.
  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == ST_IDLE && out_valid_r))
    else $error("finished item did not reach the output register");
`endif

endmodule
